// ===== design/tmfc_pkg.sv =====
package tmfc_pkg;

  // fixed field widths
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

  localparam logic [CAP_W-1:0]   CAP_RESET       = 5'd16;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hffff;
  localparam logic [COUNT_W-1:0] COUNT_ONE       = 16'd1;

  // update command broadcast to every cell
  typedef struct packed {
    logic               upd;
    logic               miss;
    logic               promote;
    logic [COUNT_W-1:0] new_count;
  } tmfc_ctl_t;

endpackage

// ===== design/threshold_move_to_front_cache_top.sv =====
// each lookup registers its key compare in the cells, then shifts the cells and registers the result
// a new lookup is taken only after the previous one has shifted; the shift stalls while the last result is unread
// the next compare waits for the shift since it sees the reordered entries
// reset (synchronous, rst_n low): buffer empty, capacity 16, threshold 10, no result pending
// writing capacity empties the buffer
module threshold_move_to_front_cache_top import tmfc_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KEY_PORT_W-1:0]   in_lookup_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [POS_W-1:0]        out_found_position,
  output logic [COUNT_W-1:0]      out_new_count,
  output logic                    out_moved_front,
  output logic                    out_evicted,
  output logic [KEY_PORT_W-1:0]   out_evicted_key,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]     capacity_r;
  logic [COUNT_W-1:0]   threshold_r;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic                 busy_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 out_valid_r;
  logic                 hit_r, moved_r, evicted_r;
  logic [POS_W-1:0]     pos_r;
  logic [COUNT_W-1:0]   count_r;
  logic [KEY_PORT_W-1:0] evkey_r;

  logic                 accept;
  logic                 finish;
  logic [CW-1:0]        cap_ext, cap_eff, last;
  logic                 full;

  logic [KEY_WIDTH-1:0] cell_key   [DEPTH];
  logic [COUNT_W-1:0]   cell_count [DEPTH];
  logic [KEY_WIDTH-1:0] cell_tail  [DEPTH];
  logic [DEPTH-1:0]     cell_first;
  logic [DEPTH:0]       any_chain;
  logic [KEY_WIDTH-1:0] left_key   [DEPTH];
  logic [COUNT_W-1:0]   left_count [DEPTH];

  logic                 hit;
  logic [IDX_W-1:0]     pos;
  logic [KEY_WIDTH-1:0] found_key, tail_key;
  logic [COUNT_W-1:0]   found_count, after_count;
  logic                 promote;
  logic                 evict;
  tmfc_ctl_t            ctl;
  logic [IDX_W+POS_W-1:0]        pos_ext;
  logic [KEY_WIDTH+KEY_PORT_W-1:0] evkey_ext;

  assign in_ready  = ~busy_r;
  assign accept    = in_valid & in_ready;
  assign finish    = busy_r & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;

  // clamp capacity to 1..DEPTH
  assign cap_ext = CW'(capacity_r);
  always_comb begin
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end
  end

  assign full = occ_r >= cap_eff;

  // gather the first match and its data from the cells
  always_comb begin
    pos         = '0;
    found_key   = '0;
    found_count = '0;
    tail_key    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        pos = IDX_W'(i);
      end
      found_key   = found_key   | (cell_first[i] ? cell_key[i] : '0);
      found_count = found_count | (cell_first[i] ? cell_count[i] : '0);
      tail_key    = tail_key    | cell_tail[i];
    end
  end

  assign hit         = any_chain[DEPTH];
  assign after_count = (found_count == COUNT_MAX) ? COUNT_MAX : found_count + COUNT_ONE;
  assign promote     = hit & (found_count >= threshold_r);
  assign evict       = ~hit & full;
  assign last        = full ? cap_eff - CW'(1) : occ_r;

  assign ctl.upd       = finish;
  assign ctl.miss      = ~hit;
  assign ctl.promote   = promote;
  assign ctl.new_count = hit ? after_count : COUNT_ONE;

  assign any_chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_front
        assign left_key[g]   = hit ? found_key : key_r;
        assign left_count[g] = hit ? after_count : COUNT_ONE;
      end else begin : g_rest
        assign left_key[g]   = cell_key[g-1];
        assign left_count[g] = cell_count[g-1];
      end

      tmfc_cell #(
        .INDEX     (g),
        .KEY_WIDTH (KEY_WIDTH),
        .CW        (CW)
      ) u_cell (
        .clk            (clk),
        .cmp_en         (accept),
        .search_key     (in_lookup_key[KEY_WIDTH-1:0]),
        .occ            (occ_r),
        .last           (last),
        .ctl            (ctl),
        .left_key       (left_key[g]),
        .left_count     (left_count[g]),
        .any_before_in  (any_chain[g]),
        .any_before_out (any_chain[g+1]),
        .first          (cell_first[g]),
        .key            (cell_key[g]),
        .count          (cell_count[g]),
        .tail_key       (cell_tail[g])
      );
    end
  endgenerate

  always_comb begin
    occ_nxt = occ_r;
    if (cfg_we && cfg_index == REG_CAPACITY) begin
      occ_nxt = '0;
    end else if (finish && !hit && !full) begin
      occ_nxt = occ_r + CW'(1);
    end
  end

  assign pos_ext   = {{POS_W{1'b0}}, pos};
  assign evkey_ext = {{KEY_PORT_W{1'b0}}, tail_key};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      threshold_r <= THRESHOLD_RESET;
      occ_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:  capacity_r  <= cfg_wdata[CAP_W-1:0];
          REG_THRESHOLD: threshold_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_lookup_key[KEY_WIDTH-1:0];
    end
    if (finish) begin
      hit_r     <= hit;
      pos_r     <= pos_ext[POS_W-1:0];
      count_r   <= hit ? after_count : COUNT_ONE;
      moved_r   <= promote;
      evicted_r <= evict;
      evkey_r   <= evict ? evkey_ext[KEY_PORT_W-1:0] : '0;
    end
  end

  assign out_hit            = hit_r;
  assign out_found_position = pos_r;
  assign out_new_count      = count_r;
  assign out_moved_front    = moved_r;
  assign out_evicted        = evicted_r;
  assign out_evicted_key    = evkey_r;

endmodule

// ===== design/tmfc_cell.sv =====
module tmfc_cell import tmfc_pkg::*; #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned KEY_WIDTH = 64,
  parameter int unsigned CW        = 5
) (
  input  logic                 clk,
  input  logic                 cmp_en,
  input  logic [KEY_WIDTH-1:0] search_key,
  input  logic [CW-1:0]        occ,
  input  logic [CW-1:0]        last,
  input  tmfc_ctl_t            ctl,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [COUNT_W-1:0]   left_count,
  input  logic                 any_before_in,
  output logic                 any_before_out,
  output logic                 first,
  output logic [KEY_WIDTH-1:0] key,
  output logic [COUNT_W-1:0]   count,
  output logic [KEY_WIDTH-1:0] tail_key
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 match_r;
  logic                 valid;
  logic                 at_last;
  logic                 shift;

  assign valid          = CW'(INDEX) < occ;
  assign at_last        = CW'(INDEX) == last;
  assign first          = match_r & ~any_before_in;
  assign any_before_out = any_before_in | match_r;
  assign key            = key_r;
  assign count          = count_r;
  assign tail_key       = at_last ? key_r : '0;

  // take the neighbor's entry: miss shifts up to the last slot, promote up to the hit
  assign shift = (ctl.miss & (CW'(INDEX) <= last)) | (ctl.promote & ~any_before_in);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= valid && (key_r == search_key);
    end
    if (ctl.upd) begin
      if (shift) begin
        key_r   <= left_key;
        count_r <= left_count;
      end else if (first) begin
        count_r <= ctl.new_count;
      end
    end
  end

endmodule
